// ----- hw/rtl/ols_pkg.sv -----
// Shared types, constants and control words for the ordered list store.
package ols_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 8;
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;

    localparam logic [VAL_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [2:0] {
        ACT_APPEND       = 3'd0,
        ACT_INSERT       = 3'd1,
        ACT_READ         = 3'd2,
        ACT_REMOVE_POS   = 3'd3,
        ACT_REMOVE_FIRST = 3'd4,
        ACT_REMOVE_LAST  = 3'd5,
        ACT_SEARCH       = 3'd6,
        ACT_REMOVE_VALUE = 3'd7
    } action_t;

    typedef struct packed {
        action_t                  action;
        logic [POS_W-1:0]         position;
        logic signed [VAL_W-1:0]  value;
    } request_t;

    typedef struct packed {
        logic                     ok;
        logic signed [VAL_W-1:0]  read_value;
        logic [POS_W-1:0]         found_position;
        logic [CNT_W-1:0]         count;
        logic                     is_full;
        logic                     is_empty;
    } result_t;

    typedef enum logic [2:0] {
        PTR_HOLD   = 3'd0,
        PTR_INC    = 3'd1,
        PTR_DEC    = 3'd2,
        PTR_ZERO   = 3'd3,
        PTR_TOP    = 3'd4,
        PTR_REMOVE = 3'd5
    } ptr_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_FETCH_WAIT,
        S_SHIFT_UP,
        S_UP_END,
        S_INS_WR,
        S_SHIFT_DN,
        S_DN_END,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    latch;
        ptr_op_t ptr_op;
        logic    rd_en;
        logic    mv_en;
        logic    mv_up;
        logic    wr_append;
        logic    wr_insert;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    res_val;
        logic    res_rd;
        logic    res_hit;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        action_t action;
        logic    full;
        logic    nonempty;
        logic    ins_ok;
        logic    ins_shift;
        logic    rm_ok;
        logic    more;
        logic    last_up;
        logic    hit;
    } dp_stat_t;

endpackage

// ----- hw/rtl/ordered_list_store_core.sv -----
// Ordered list store: top level joining the controller and the datapath.
// Append and any word failing its checks finish straight after decode; read fetches one entry;
// insert and remove at position, first or last also move the entries behind the position;
// search scans from the first entry; remove value scans, then moves the entries after a hit.
// One word at a time: a new word is taken only while idle, in the cycle after
// the result strobe, which cannot be held off. Reset clears count and control only.
module ordered_list_store_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ols_pkg::request_t request,
    output logic              busy,
    output logic              done,
    output ols_pkg::result_t  result
);
    import ols_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ols_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    ols_dpath u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

endmodule

// ----- hw/rtl/ols_dpath.sv -----
// Datapath: entry memory, count, scan pointer, move pipe and result registers.
module ols_dpath (
    input  logic              clk,
    input  logic              rst_n,
    input  ols_pkg::request_t request,
    input  ols_pkg::dp_cmd_t  cmd,
    output ols_pkg::dp_stat_t stat,
    output ols_pkg::result_t  result
);
    import ols_pkg::*;

    localparam logic [CNT_W:0] CAP_X = (CNT_W+1)'(CAPACITY);

    logic [VAL_W-1:0] mem [CAPACITY];

    request_t          op_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [IDX_W-1:0]  ptr_reg;
    logic [IDX_W-1:0]  ptr_next;
    logic [VAL_W-1:0]  rdata_reg;
    logic              mv_pend_reg;
    logic [IDX_W-1:0]  mv_addr_reg;
    logic              ok_reg;
    logic [VAL_W-1:0]  rv_reg;
    logic [POS_W-1:0]  fp_reg;

    logic              full;
    logic [CNT_W:0]    pos_x;
    logic [CNT_W:0]    cnt_x;
    logic [CNT_W:0]    ptr_x;
    logic [CNT_W:0]    top_slot;
    logic [CNT_W:0]    rm_pos;
    logic [IDX_W-1:0]  ins_addr;

    // Decode position checks from the held word and the count
    assign full     = (count_reg == CAP_X[CNT_W-1:0]);
    assign pos_x    = {1'b0, op_reg.position};
    assign cnt_x    = {1'b0, count_reg};
    assign ptr_x    = (CNT_W+1)'(ptr_reg);
    assign top_slot = full ? (CAP_X - 1'b1) : cnt_x;
    assign ins_addr = IDX_W'(pos_x - 1'b1);

    always_comb
    begin
        unique case (op_reg.action)
            ACT_REMOVE_FIRST: rm_pos = (CNT_W+1)'(1);
            ACT_REMOVE_LAST:  rm_pos = cnt_x;
            default:          rm_pos = pos_x;
        endcase
    end

    always_comb
    begin
        stat.action    = op_reg.action;
        stat.full      = full;
        stat.nonempty  = (count_reg != '0);
        stat.ins_ok    = (pos_x != '0) &&
                         (full ? (pos_x <= CAP_X) : (pos_x <= cnt_x + 1'b1));
        stat.ins_shift = (pos_x <= top_slot);
        stat.rm_ok     = (rm_pos != '0) && (rm_pos <= cnt_x);
        stat.more      = (ptr_x + 1'b1) < cnt_x;
        stat.last_up   = (ptr_x + 1'b1) == pos_x;
        stat.hit       = (rdata_reg == op_reg.value);
    end

    // Select the next pointer
    always_comb
    begin
        unique case (cmd.ptr_op)
            PTR_HOLD:   ptr_next = ptr_reg;
            PTR_INC:    ptr_next = ptr_reg + 1'b1;
            PTR_DEC:    ptr_next = ptr_reg - 1'b1;
            PTR_ZERO:   ptr_next = '0;
            PTR_TOP:    ptr_next = IDX_W'(top_slot - 1'b1);
            PTR_REMOVE: ptr_next = IDX_W'(rm_pos - 1'b1);
            default:    ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        priority if (cmd.cnt_inc)
            count_next = count_reg + 1'b1;
        else if (cmd.cnt_dec)
            count_next = count_reg - 1'b1;
        else
            count_next = count_reg;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ptr_reg     <= '0;
            mv_pend_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            mv_pend_reg <= cmd.rd_en && cmd.mv_en;
        end
    end

    // Capture the word and the move target
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            op_reg <= request;
        if (cmd.rd_en && cmd.mv_en)
            mv_addr_reg <= cmd.mv_up ? (ptr_reg + 1'b1) : (ptr_reg - 1'b1);
    end

    // Write the memory: a pending move first, then a new value
    always_ff @(posedge clk)
    begin
        priority if (mv_pend_reg)
            mem[mv_addr_reg] <= rdata_reg;
        else if (cmd.wr_append)
            mem[count_reg[IDX_W-1:0]] <= op_reg.value;
        else if (cmd.wr_insert)
            mem[ins_addr] <= op_reg.value;
    end

    // Read the memory at the pointer
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rdata_reg <= mem[ptr_reg];
    end

    // Build the result fields
    always_ff @(posedge clk)
    begin
        priority if (cmd.latch)
        begin
            ok_reg <= 1'b0;
            rv_reg <= EMPTY_WORD;
            fp_reg <= '0;
        end
        else if (cmd.res_val)
        begin
            ok_reg <= 1'b1;
            rv_reg <= op_reg.value;
        end
        else if (cmd.res_rd)
        begin
            ok_reg <= 1'b1;
            rv_reg <= rdata_reg;
        end
        else if (cmd.res_hit)
        begin
            ok_reg <= 1'b1;
            rv_reg <= op_reg.value;
            fp_reg <= POS_W'(ptr_x + 1'b1);
        end
    end

    assign result.ok             = ok_reg;
    assign result.read_value     = rv_reg;
    assign result.found_position = fp_reg;
    assign result.count          = count_reg;
    assign result.is_full        = full;
    assign result.is_empty       = (count_reg == '0);

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mv_pend_reg && (cmd.wr_append || cmd.wr_insert)))
        else $error("value write collides with a pending move");

    a_grow_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> (count_reg < CAP_X[CNT_W-1:0]))
        else $error("count grows past capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("count did not drop by one");

endmodule

// ----- hw/rtl/ols_ctrl.sv -----
// Controller: sequences each operation over the datapath.
module ols_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ols_pkg::dp_stat_t stat,
    output logic              busy,
    output logic              done,
    output ols_pkg::dp_cmd_t  cmd
);
    import ols_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                    state_next = S_DECODE;
            S_DECODE:
            begin
                unique case (stat.action)
                    ACT_APPEND:
                        state_next = S_DONE;
                    ACT_INSERT:
                        if (!stat.ins_ok)
                            state_next = S_DONE;
                        else if (stat.ins_shift)
                            state_next = S_SHIFT_UP;
                        else
                            state_next = S_INS_WR;
                    ACT_READ, ACT_REMOVE_POS, ACT_REMOVE_FIRST, ACT_REMOVE_LAST:
                        state_next = stat.rm_ok ? S_FETCH : S_DONE;
                    ACT_SEARCH, ACT_REMOVE_VALUE:
                        state_next = stat.nonempty ? S_SCAN_RD : S_DONE;
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_FETCH:
                state_next = S_FETCH_WAIT;
            S_FETCH_WAIT:
                if (stat.action != ACT_READ && stat.more)
                    state_next = S_SHIFT_DN;
                else
                    state_next = S_DONE;
            S_SHIFT_UP:
                if (stat.last_up)
                    state_next = S_UP_END;
            S_UP_END:
                state_next = S_INS_WR;
            S_INS_WR:
                state_next = S_DONE;
            S_SHIFT_DN:
                if (!stat.more)
                    state_next = S_DN_END;
            S_DN_END:
                state_next = S_DONE;
            S_SCAN_RD:
                state_next = S_SCAN_CMP;
            S_SCAN_CMP:
                if (stat.hit)
                begin
                    if (stat.action == ACT_SEARCH)
                        state_next = S_DONE;
                    else if (stat.more)
                        state_next = S_SHIFT_DN;
                    else
                        state_next = S_DONE;
                end
                else if (stat.more)
                    state_next = S_SCAN_RD;
                else
                    state_next = S_DONE;
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Drive datapath commands and handshake
    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        done = (state_reg == S_DONE);
        unique case (state_reg)
            S_IDLE:
                cmd.latch = start;
            S_DECODE:
            begin
                unique case (stat.action)
                    ACT_APPEND:
                        if (!stat.full)
                        begin
                            cmd.wr_append = 1'b1;
                            cmd.cnt_inc   = 1'b1;
                            cmd.res_val   = 1'b1;
                        end
                    ACT_INSERT:
                        cmd.ptr_op = PTR_TOP;
                    ACT_READ, ACT_REMOVE_POS, ACT_REMOVE_FIRST, ACT_REMOVE_LAST:
                        cmd.ptr_op = PTR_REMOVE;
                    ACT_SEARCH, ACT_REMOVE_VALUE:
                        cmd.ptr_op = PTR_ZERO;
                    default:
                        cmd.ptr_op = PTR_HOLD;
                endcase
            end
            S_FETCH:
                cmd.rd_en = 1'b1;
            S_FETCH_WAIT:
            begin
                cmd.res_rd = 1'b1;
                if (stat.action != ACT_READ)
                begin
                    if (stat.more)
                        cmd.ptr_op = PTR_INC;
                    else
                        cmd.cnt_dec = 1'b1;
                end
            end
            S_SHIFT_UP:
            begin
                cmd.rd_en = 1'b1;
                cmd.mv_en = 1'b1;
                cmd.mv_up = 1'b1;
                if (!stat.last_up)
                    cmd.ptr_op = PTR_DEC;
            end
            S_UP_END:
                cmd.ptr_op = PTR_HOLD;
            S_INS_WR:
            begin
                cmd.wr_insert = 1'b1;
                cmd.res_val   = 1'b1;
                cmd.cnt_inc   = !stat.full;
            end
            S_SHIFT_DN:
            begin
                cmd.rd_en = 1'b1;
                cmd.mv_en = 1'b1;
                if (stat.more)
                    cmd.ptr_op = PTR_INC;
            end
            S_DN_END:
                cmd.cnt_dec = 1'b1;
            S_SCAN_RD:
                cmd.rd_en = 1'b1;
            S_SCAN_CMP:
                if (stat.hit)
                begin
                    cmd.res_hit = 1'b1;
                    if (stat.action == ACT_REMOVE_VALUE)
                    begin
                        if (stat.more)
                            cmd.ptr_op = PTR_INC;
                        else
                            cmd.cnt_dec = 1'b1;
                    end
                end
                else if (stat.more)
                    cmd.ptr_op = PTR_INC;
            S_DONE:
                cmd.ptr_op = PTR_HOLD;
            default:
                cmd.ptr_op = PTR_HOLD;
        endcase
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block stayed busy after its result");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the ordered list store core.
`timescale 1ns / 100ps

import ols_pkg::*;

class list_scoreboard;
    logic [VAL_W-1:0] slot [CAPACITY];
    int               used;
    result_t          expected [$];
    request_t         asked [$];
    int unsigned      mismatches;
    int unsigned      words;
    int unsigned      successes;
    int unsigned      full_words;
    int unsigned      peak;
    int unsigned      per_action [8];

    function new();
        foreach (slot[i])
            slot[i] = EMPTY_WORD;
        used = 0;
    endfunction

    task report(string msg);
        if (mismatches < 40)
            $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    // Close the gap left by the entry at zero-based index idx
    function void drop(int idx);
        int i;
        for (i = idx; i + 1 < used; i++)
            slot[i] = slot[i + 1];
        slot[used - 1] = EMPTY_WORD;
        used--;
    endfunction

    // One-based position of the first entry equal to v, 0 if none
    function int locate(logic [VAL_W-1:0] v);
        int i;
        for (i = 0; i < used; i++)
            if (slot[i] == v)
                return i + 1;
        return 0;
    endfunction

    // Apply an accepted word to the list and queue the result it must give
    function void note(request_t r);
        result_t          want;
        logic [VAL_W-1:0] v;
        int               p;
        int               hit;
        int               i;
        want = '0;
        want.read_value = EMPTY_WORD;
        v = r.value;
        p = int'(r.position);
        case (r.action)
            ACT_APPEND:
                if (used < CAPACITY)
                begin
                    slot[used] = v;
                    used++;
                    want.ok = 1'b1;
                    want.read_value = v;
                end
            ACT_INSERT:
                if (used < CAPACITY)
                begin
                    if (p >= 1 && p <= used + 1)
                    begin
                        for (i = used; i >= p; i--)
                            slot[i] = slot[i - 1];
                        slot[p - 1] = v;
                        used++;
                        want.ok = 1'b1;
                        want.read_value = v;
                    end
                end
                else if (p >= 1 && p <= CAPACITY)
                begin
                    // full list: the last entry falls off the end
                    for (i = CAPACITY - 1; i >= p; i--)
                        slot[i] = slot[i - 1];
                    slot[p - 1] = v;
                    want.ok = 1'b1;
                    want.read_value = v;
                end
            ACT_READ:
                if (p >= 1 && p <= used)
                begin
                    want.ok = 1'b1;
                    want.read_value = slot[p - 1];
                end
            ACT_REMOVE_POS, ACT_REMOVE_FIRST, ACT_REMOVE_LAST:
            begin
                if (r.action == ACT_REMOVE_FIRST)
                    p = 1;
                else if (r.action == ACT_REMOVE_LAST)
                    p = used;
                if (p >= 1 && p <= used)
                begin
                    want.ok = 1'b1;
                    want.read_value = slot[p - 1];
                    drop(p - 1);
                end
            end
            default:
            begin
                hit = locate(v);
                want.found_position = hit[POS_W-1:0];
                if (hit != 0)
                begin
                    want.ok = 1'b1;
                    want.read_value = v;
                    if (r.action == ACT_REMOVE_VALUE)
                        drop(hit - 1);
                end
            end
        endcase
        want.count = used[CNT_W-1:0];
        want.is_full = (used == CAPACITY);
        want.is_empty = (used == 0);

        words++;
        per_action[r.action]++;
        if (want.ok)
            successes++;
        if (want.is_full)
            full_words++;
        if (used > peak)
            peak = used;
        expected.push_back(want);
        asked.push_back(r);
    endfunction

    task compare_field(request_t r, string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("%s on %s pos %0d value %0d: got %0h want %0h", name,
                             r.action.name(), r.position, r.value, got, want));
    endtask

    // Check one result word against the oldest outstanding expectation
    task check(result_t got);
        result_t  want;
        request_t r;
        if (expected.size() == 0)
        begin
            report("result strobe with no word outstanding");
            return;
        end
        want = expected.pop_front();
        r = asked.pop_front();
        compare_field(r, "ok", 32'(got.ok), 32'(want.ok));
        compare_field(r, "read_value", got.read_value, want.read_value);
        compare_field(r, "found_position", 32'(got.found_position),
                      32'(want.found_position));
        compare_field(r, "count", 32'(got.count), 32'(want.count));
        compare_field(r, "is_full", 32'(got.is_full), 32'(want.is_full));
        compare_field(r, "is_empty", 32'(got.is_empty), 32'(want.is_empty));
    endtask

    function int pending();
        return expected.size();
    endfunction
endclass

module tb;

    localparam int RANDOM_WORDS = 830;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     done;
    result_t  result;

    list_scoreboard sb = new();

    ordered_list_store_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check results first: a result always belongs to an earlier word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check(result);
            if (start && !busy)
                sb.note(request);
        end
    end

    function automatic request_t word(action_t a, int p, logic [VAL_W-1:0] v);
        request_t r;
        r.action = a;
        r.position = p[POS_W-1:0];
        r.value = v;
        return r;
    endfunction

    // Drive one word at a falling edge, hold until taken, return at a falling edge
    task automatic send(request_t r);
        start <= 1'b1;
        request <= r;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        @(negedge clk);
    endtask

    task automatic pause(int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Hold off until every outstanding result has come back
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
    endtask

    // Values: mostly entries already stored or a small pool, so searches hit
    function automatic logic [VAL_W-1:0] pick_value();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45 && sb.used > 0)
            return sb.slot[$urandom_range(0, sb.used - 1)];
        if (k < 70)
            return $urandom_range(0, 7) - 4;
        if (k < 75)
            return k[0] ? 32'h8000_0000 : 32'h7fff_ffff;
        return $urandom();
    endfunction

    function automatic int pick_position();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60)
            return $urandom_range(1, sb.used + 1);
        if (k < 70)
            return 0;
        if (k < 80)
            return sb.used + 1;
        if (k < 85)
            return CAPACITY;
        return $urandom_range(0, 255);
    endfunction

    // Mode 0 grows the list, 1 mixes evenly, 2 shrinks it
    function automatic request_t random_word(int mode);
        int      k;
        action_t a;
        k = $urandom_range(0, 99);
        a = action_t'($urandom_range(0, 7));
        if (mode == 0)
        begin
            if (k < 55)
                a = ACT_APPEND;
            else if (k < 85)
                a = ACT_INSERT;
        end
        else if (mode == 2)
        begin
            if (k < 25)
                a = ACT_REMOVE_POS;
            else if (k < 40)
                a = ACT_REMOVE_FIRST;
            else if (k < 55)
                a = ACT_REMOVE_LAST;
            else if (k < 75)
                a = ACT_REMOVE_VALUE;
        end
        return word(a, pick_position(), pick_value());
    endfunction

    function automatic int mode_for(int n);
        if (n < 220 || (n >= 650 && n < 760))
            return 0;
        if (n >= 360 && n < 560)
            return 2;
        return 1;
    endfunction

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int burst;
        int n;
        burst = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty list failures, bounds, sign extremes, duplicates
        send(word(ACT_REMOVE_FIRST, 0, 0));
        send(word(ACT_REMOVE_LAST, 0, 0));
        send(word(ACT_READ, 1, 0));
        send(word(ACT_REMOVE_POS, 0, 0));
        send(word(ACT_SEARCH, 0, 0));
        send(word(ACT_REMOVE_VALUE, 0, EMPTY_WORD));
        send(word(ACT_INSERT, 2, 7));
        send(word(ACT_INSERT, 1, 32'h8000_0000));
        send(word(ACT_APPEND, 0, 32'h7fff_ffff));
        send(word(ACT_APPEND, 255, EMPTY_WORD));
        send(word(ACT_INSERT, 4, 5));
        send(word(ACT_INSERT, 6, 9));
        send(word(ACT_INSERT, 0, 9));
        send(word(ACT_INSERT, 255, 9));
        send(word(ACT_READ, 0, 0));
        send(word(ACT_READ, 4, 0));
        send(word(ACT_READ, 5, 0));
        send(word(ACT_SEARCH, 0, EMPTY_WORD));
        send(word(ACT_APPEND, 0, EMPTY_WORD));
        send(word(ACT_REMOVE_VALUE, 0, EMPTY_WORD));
        send(word(ACT_REMOVE_POS, 2, 0));
        send(word(ACT_REMOVE_LAST, 0, 0));
        send(word(ACT_REMOVE_FIRST, 0, 0));
        send(word(ACT_REMOVE_POS, 255, 0));
        send(word(ACT_REMOVE_LAST, 0, 0));

        // Random: bursts with gaps, one stretch without idling, one full drain
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 24);
                if (n < 300 || n >= 420)
                    pause($urandom_range(1, ($urandom_range(0, 3) == 0) ? 30 : 3));
            end
            burst--;
            if (n == 500)
                drain();
            send(random_word(mode_for(n)));
        end

        drain();
        repeat (300) @(negedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));

        $display("Covered %0d words, %0d succeeded; peak fill %0d of %0d, %0d at full list.",
                 sb.words, sb.successes, sb.peak, CAPACITY, sb.full_words);
        $display("Per operation: app %0d ins %0d rd %0d rmp %0d rmf %0d rml %0d srch %0d rmv %0d",
                 sb.per_action[ACT_APPEND], sb.per_action[ACT_INSERT],
                 sb.per_action[ACT_READ], sb.per_action[ACT_REMOVE_POS],
                 sb.per_action[ACT_REMOVE_FIRST], sb.per_action[ACT_REMOVE_LAST],
                 sb.per_action[ACT_SEARCH], sb.per_action[ACT_REMOVE_VALUE]);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
